@@ rtl/nrt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nrt_pkg
// Types, constants and payload formats shared by the node request tracker.
// ----------------------------------------------------------------------------
package nrt_pkg;

  localparam int unsigned NODES_DEF   = 16;
  localparam int unsigned CATEGORIES  = 5;
  localparam int unsigned IN_W        = 120;
  localparam int unsigned OUT_W       = 48;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam logic [31:0] FRESH_RST   = 32'd5000;
  localparam logic [31:0] TIMEOUT_RST = 32'd2000;

  typedef enum logic [3:0] {
    K_PREP_STATUS = 4'd0,
    K_PREP_PAGE   = 4'd1,
    K_COMPL_PAGE  = 4'd2,
    K_CLEAR_PAGE  = 4'd3,
    K_CLEAR_PEND  = 4'd4,
    K_STATUS_UPD  = 4'd5,
    K_PAGE_DATA   = 4'd6,
    K_INVALIDATE  = 4'd7,
    K_QUERY       = 4'd8
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_FRESH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 8'd1;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] node_id;
    logic [31:0] time_ms;
    logic [2:0]  category;
    logic [15:0] page_offset;
    logic        new_has_plc;
    logic        new_has_rtc;
    logic        new_pending;
    logic [31:0] new_started_ms;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic        found;
    logic        has_plc;
    logic        has_rtc;
    logic        pending;
    logic [4:0]  page_pending_mask;
    logic [31:0] updated_at;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } bstate_t;

endpackage
`default_nettype wire

@@ rtl/nrt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nrt_front
// Accepts request beats, unpacks them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module nrt_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  input  wire [nrt_pkg::IN_W-1:0]   in_tdata,
  input  wire [3:0]                 in_tuser,
  output logic                      q_valid,
  input  wire                       q_pop,
  output nrt_pkg::req_t             q_req
);
  import nrt_pkg::*;

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  req_t       inr;
  logic       push;

  always_comb begin
    inr.kind           = in_tuser;
    inr.node_id        = in_tdata[31:0];
    inr.time_ms        = in_tdata[63:32];
    inr.category       = in_tdata[66:64];
    inr.page_offset    = in_tdata[82:67];
    inr.new_has_plc    = in_tdata[83];
    inr.new_has_rtc    = in_tdata[84];
    inr.new_pending    = in_tdata[85];
    inr.new_started_ms = in_tdata[117:86];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_req     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= inr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_tready) else $error("accept while full");
`endif
endmodule
`default_nettype wire

@@ rtl/nrt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nrt_back
// Executes one request: parallel id match in the first cycle, then a
// read-modify-write of the matched or allocated entry and the result.
// ----------------------------------------------------------------------------
module nrt_back #(
  parameter int unsigned NODES = nrt_pkg::NODES_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                q_valid,
  output logic               q_pop,
  input  nrt_pkg::req_t      q_req,
  input  wire [31:0]         fresh_window,
  input  wire [31:0]         pending_timeout,
  output logic               out_tvalid,
  input  wire                out_tready,
  output nrt_pkg::rsp_t      out_rsp
);
  import nrt_pkg::*;

  localparam int unsigned SW = (NODES > 1) ? $clog2(NODES) : 1;

  logic [NODES-1:0]  used_r;
  logic [31:0]       node_r    [NODES];
  logic [31:0]       upd_r     [NODES];
  logic [2:0]        flags_r   [NODES];
  logic [31:0]       start_r   [NODES];
  logic [CATEGORIES-1:0] pbusy_r [NODES];
  logic [15:0]       poff_r    [NODES][CATEGORIES];
  logic [31:0]       pstart_r  [NODES][CATEGORIES];

  bstate_t st_r, st_nxt;
  req_t    req_r;
  logic    hit_r, freeav_r;
  logic [SW-1:0] hs_r, fs_r;
  rsp_t    rsp_r, rsp_nxt;

  logic          hit_c, free_c;
  logic [SW-1:0] hs_c, fs_c;

  always_comb begin
    hit_c = 1'b0; free_c = 1'b0; hs_c = '0; fs_c = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (used_r[i] && node_r[i] == q_req.node_id) begin
        hit_c = 1'b1; hs_c = SW'(i);
      end
      if (!used_r[i]) begin
        free_c = 1'b1; fs_c = SW'(i);
      end
    end
  end

  // execute-cycle decode
  logic          cat_ok, allocs, exist, do_alloc, wr;
  logic [SW-1:0] s;
  logic [2:0]    cat;
  logic [2:0]    f;
  logic          busy, both, pmatch, ptime, fresh;
  logic          ok;
  logic          found;

  always_comb begin
    cat    = (req_r.category < 3'(CATEGORIES)) ? req_r.category : 3'd0;
    cat_ok = req_r.category < 3'(CATEGORIES);
    case (req_r.kind)
      K_PREP_STATUS, K_STATUS_UPD, K_PAGE_DATA: allocs = 1'b1;
      K_PREP_PAGE: allocs = cat_ok;
      default:     allocs = 1'b0;
    endcase
    do_alloc = allocs && !hit_r && freeav_r && (req_r.node_id != 32'd0);
    exist    = hit_r || do_alloc;
    s        = hit_r ? hs_r : fs_r;
    f        = do_alloc ? 3'd0 : flags_r[s];
    fresh    = ((req_r.time_ms - (do_alloc ? 32'd0 : upd_r[s])) < fresh_window);
    busy     = f[2] && ((req_r.time_ms - (do_alloc ? 32'd0 : start_r[s]))
               < pending_timeout);
    both     = f[0] && f[1] && fresh;
    pmatch   = !do_alloc && pbusy_r[s][cat] && (poff_r[s][cat] == req_r.page_offset);
    ptime    = (req_r.time_ms - pstart_r[s][cat]) < pending_timeout;
    ok = 1'b0;
    found = exist;
    case (req_r.kind)
      K_PREP_STATUS: ok = exist && !busy && !both;
      K_PREP_PAGE:   ok = exist && cat_ok && !(pmatch && ptime);
      K_COMPL_PAGE:  ok = hit_r && cat_ok && pmatch;
      K_CLEAR_PAGE:  ok = hit_r && cat_ok;
      K_CLEAR_PEND, K_STATUS_UPD, K_PAGE_DATA, K_QUERY: ok = exist;
      K_INVALIDATE: begin
        ok = hit_r; found = 1'b0;
      end
      default: ok = 1'b0;
    endcase
    if (req_r.node_id == 32'd0) begin
      ok = 1'b0; found = 1'b0;
    end
    wr = (st_r == ST_EXEC);
    rsp_nxt = '0;
    rsp_nxt.ok = ok;
    rsp_nxt.found = found;
    if (req_r.kind == K_QUERY && ok) begin
      rsp_nxt.has_plc = f[0];
      rsp_nxt.has_rtc = f[1];
      rsp_nxt.pending = f[2];
      rsp_nxt.page_pending_mask = 5'(pbusy_r[s]);
      rsp_nxt.updated_at = upd_r[s];
    end
  end

  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    case (st_r)
      ST_IDLE: if (q_valid) begin
        q_pop = 1'b1; st_nxt = ST_EXEC;
      end
      ST_EXEC: st_nxt = ST_OUT;
      ST_OUT:  if (out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = (st_r == ST_OUT);
  assign out_rsp    = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r    <= q_req;
      hit_r    <= hit_c;
      freeav_r <= free_c;
      hs_r     <= hs_c;
      fs_r     <= fs_c;
    end
    if (wr) rsp_r <= rsp_nxt;
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (wr && do_alloc) begin
      node_r[s]  <= req_r.node_id;
      upd_r[s]   <= '0;
      flags_r[s] <= '0;
      start_r[s] <= '0;
      for (int c = 0; c < CATEGORIES; c++) begin
        poff_r[s][c]   <= '0;
        pstart_r[s][c] <= '0;
      end
    end
    if (wr && ok) begin
      case (req_r.kind)
        K_PREP_STATUS: begin
          flags_r[s] <= f | 3'b100; start_r[s] <= req_r.time_ms;
        end
        K_PREP_PAGE: begin
          poff_r[s][cat] <= req_r.page_offset; pstart_r[s][cat] <= req_r.time_ms;
        end
        K_COMPL_PAGE, K_CLEAR_PAGE: begin
          poff_r[s][cat] <= '0; pstart_r[s][cat] <= '0;
        end
        K_CLEAR_PEND: begin
          flags_r[s] <= {1'b0, f[1:0]}; start_r[s] <= '0;
        end
        K_STATUS_UPD: begin
          flags_r[s] <= {req_r.new_pending, req_r.new_has_rtc, req_r.new_has_plc};
          start_r[s] <= req_r.new_started_ms;
          upd_r[s]   <= req_r.time_ms;
        end
        K_PAGE_DATA: upd_r[s] <= req_r.time_ms;
        K_INVALIDATE: begin
          node_r[s] <= '0; upd_r[s] <= '0; flags_r[s] <= '0; start_r[s] <= '0;
          for (int c = 0; c < CATEGORIES; c++) begin
            poff_r[s][c]   <= '0;
            pstart_r[s][c] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < NODES; i++) pbusy_r[i] <= '0;
    end else if (wr) begin
      if (do_alloc) begin
        used_r[s]  <= 1'b1;
        pbusy_r[s] <= '0;
      end
      if (ok) begin
        case (req_r.kind)
          K_PREP_PAGE: pbusy_r[s][cat] <= 1'b1;
          K_COMPL_PAGE, K_CLEAR_PAGE: pbusy_r[s][cat] <= 1'b0;
          K_INVALIDATE: begin
            used_r[s] <= 1'b0; pbusy_r[s] <= '0;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EXEC) |=> (st_r == ST_OUT)) else $error("execute not followed by result");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == ST_IDLE)) else $error("pop while busy");
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_EXEC) && req_r.node_id == 32'd0) |=> !rsp_r.found)
    else $error("zero node id found");
`endif
endmodule
`default_nettype wire

@@ rtl/node_request_tracker_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// node_request_tracker_table
// Table of remote nodes that suppresses duplicate in-flight requests.
// ----------------------------------------------------------------------------
// Each request beat gives one result beat. In the execution unit a request
// is popped and its id matched against all entries in parallel, then the
// selected entry is read, modified and written, and then the result is
// presented. A two-beat queue in front keeps accepting requests while a
// result waits, until full. The table needs no clearing pass after reset.
module node_request_tracker_table #(
  parameter int unsigned NODES = nrt_pkg::NODES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // node_id, time_ms, category, page_offset, new_has_plc, new_has_rtc,
  // new_pending, new_started_ms, zero pad
  input  wire [nrt_pkg::IN_W-1:0]      in_tdata,
  // kind
  input  wire [3:0]                    in_tuser,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // ok, found, has_plc, has_rtc, pending, page_pending_mask, updated_at, pad
  output logic [nrt_pkg::OUT_W-1:0]    out_tdata,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [nrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]                   cfg_data
);
  import nrt_pkg::*;

  logic  q_valid, q_pop;
  req_t  q_req;
  rsp_t  rsp;
  logic [31:0] fresh_r, timeout_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r   <= FRESH_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FRESH)   fresh_r   <= cfg_data;
      if (cfg_index == REG_TIMEOUT) timeout_r <= cfg_data;
    end
  end

  nrt_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_valid, .q_pop, .q_req
  );

  nrt_back #(.NODES(NODES)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_req,
    .fresh_window(fresh_r), .pending_timeout(timeout_r),
    .out_tvalid, .out_tready, .out_rsp(rsp)
  );

  assign out_tdata = {6'd0, rsp.updated_at, rsp.page_pending_mask, rsp.pending,
                      rsp.has_rtc, rsp.has_plc, rsp.found, rsp.ok};
endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the node request tracker table. Request beats are
// sent one at a time, a local model of the table predicts each result, and
// every result beat is compared field by field against the oldest prediction.
// Both stream sides idle and stall at random, and the freshness window and
// pending timeout are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import nrt_pkg::*;

  localparam int NSLOT = NODES_DEF;
  localparam int LIMIT = 1000000;

  typedef struct {
    bit [3:0]  kind;
    bit [31:0] node_id;
    bit [31:0] time_ms;
    bit [2:0]  category;
    bit [15:0] page_offset;
    bit        new_has_plc;
    bit        new_has_rtc;
    bit        new_pending;
    bit [31:0] new_started_ms;
  } request_s;

  typedef struct {
    bit        ok;
    bit        found;
    bit        has_plc;
    bit        has_rtc;
    bit        pending;
    bit [4:0]  mask;
    bit [31:0] updated_at;
  } answer_s;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  wire              in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic [3:0]       in_tuser = '0;
  wire              out_tvalid;
  logic             out_tready = 1'b0;
  wire [OUT_W-1:0]  out_tdata;
  logic             cfg_valid = 1'b0;
  wire              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  bit        ent_used [NSLOT];
  bit [31:0] ent_node [NSLOT];
  bit [31:0] ent_upd [NSLOT];
  bit [2:0]  ent_flags [NSLOT];
  bit [31:0] ent_start [NSLOT];
  bit        pg_busy [NSLOT*CATEGORIES];
  bit [15:0] pg_off [NSLOT*CATEGORIES];
  bit [31:0] pg_start [NSLOT*CATEGORIES];
  bit [31:0] fresh_win = FRESH_RST;
  bit [31:0] pend_tmo = TIMEOUT_RST;

  answer_s   answers_due [$];
  int        errors = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;
  int        hold_cycles = 0;
  int        stall_left = 0;
  int        run_left = 0;
  bit [31:0] clock_ms = 32'd100;

  always #6 clk = ~clk;

  node_request_tracker_table i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic int find_node(bit [31:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (ent_used[i] && ent_node[i] == id) return i;
    return -1;
  endfunction

  function automatic void wipe_slot(int s);
    ent_used[s] = 0;
    ent_node[s] = 0;
    ent_upd[s] = 0;
    ent_flags[s] = 0;
    ent_start[s] = 0;
    for (int c = 0; c < CATEGORIES; c++) begin
      pg_busy[s*CATEGORIES+c] = 0;
      pg_off[s*CATEGORIES+c] = 0;
      pg_start[s*CATEGORIES+c] = 0;
    end
  endfunction

  function automatic int claim_slot(bit [31:0] id);
    int s;
    s = find_node(id);
    if (s >= 0) return s;
    for (int i = 0; i < NSLOT; i++)
      if (!ent_used[i]) begin
        wipe_slot(i);
        ent_used[i] = 1;
        ent_node[i] = id;
        return i;
      end
    return -1;
  endfunction

  function automatic answer_s track_request(request_s r);
    answer_s a;
    int s;
    int p;
    bit cat_ok;
    bit busy;
    bit both;
    a = '{default: 0};
    s = -1;
    cat_ok = r.category < CATEGORIES;
    if (r.node_id == 0) return a;
    case (r.kind)
      K_PREP_STATUS: begin
        s = claim_slot(r.node_id);
        if (s >= 0) begin
          busy = ent_flags[s][2] && (r.time_ms - ent_start[s]) < pend_tmo;
          both = ent_flags[s][0] && ent_flags[s][1] && (r.time_ms - ent_upd[s]) < fresh_win;
          if (!busy && !both) begin
            ent_flags[s][2] = 1;
            ent_start[s] = r.time_ms;
            a.ok = 1;
          end
        end
      end
      K_PREP_PAGE: begin
        if (!cat_ok) s = find_node(r.node_id);
        else begin
          s = claim_slot(r.node_id);
          if (s >= 0) begin
            p = s*CATEGORIES + r.category;
            if (!(pg_busy[p] && pg_off[p] == r.page_offset &&
                  (r.time_ms - pg_start[p]) < pend_tmo)) begin
              pg_busy[p] = 1;
              pg_off[p] = r.page_offset;
              pg_start[p] = r.time_ms;
              a.ok = 1;
            end
          end
        end
      end
      K_COMPL_PAGE: begin
        s = find_node(r.node_id);
        if (s >= 0 && cat_ok) begin
          p = s*CATEGORIES + r.category;
          if (pg_busy[p] && pg_off[p] == r.page_offset) begin
            pg_busy[p] = 0;
            pg_off[p] = 0;
            pg_start[p] = 0;
            a.ok = 1;
          end
        end
      end
      K_CLEAR_PAGE: begin
        s = find_node(r.node_id);
        if (s >= 0 && cat_ok) begin
          p = s*CATEGORIES + r.category;
          pg_busy[p] = 0;
          pg_off[p] = 0;
          pg_start[p] = 0;
          a.ok = 1;
        end
      end
      K_CLEAR_PEND: begin
        s = find_node(r.node_id);
        if (s >= 0) begin
          ent_flags[s][2] = 0;
          ent_start[s] = 0;
          a.ok = 1;
        end
      end
      K_STATUS_UPD: begin
        s = claim_slot(r.node_id);
        if (s >= 0) begin
          ent_flags[s] = {r.new_pending, r.new_has_rtc, r.new_has_plc};
          ent_start[s] = r.new_started_ms;
          ent_upd[s] = r.time_ms;
          a.ok = 1;
        end
      end
      K_PAGE_DATA: begin
        s = claim_slot(r.node_id);
        if (s >= 0) begin
          ent_upd[s] = r.time_ms;
          a.ok = 1;
        end
      end
      K_INVALIDATE: begin
        s = find_node(r.node_id);
        if (s >= 0) begin
          wipe_slot(s);
          a.ok = 1;
        end
        s = -1;
      end
      K_QUERY: begin
        s = find_node(r.node_id);
        if (s >= 0) begin
          a.ok = 1;
          a.has_plc = ent_flags[s][0];
          a.has_rtc = ent_flags[s][1];
          a.pending = ent_flags[s][2];
          for (int c = 0; c < CATEGORIES; c++) a.mask[c] = pg_busy[s*CATEGORIES+c];
          a.updated_at = ent_upd[s];
        end
      end
      default: s = find_node(r.node_id);
    endcase
    a.found = s >= 0;
    return a;
  endfunction

  task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
    $display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic check_field(string what, bit [31:0] got, bit [31:0] want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Result beats are sampled with the values that stood before the edge.
  always @(posedge clk) begin
    answer_s want;
    if (rst_n && out_tvalid && out_tready) begin
      if (answers_due.size() == 0) report_mismatch("unexpected beat", out_tdata[31:0], 0);
      else begin
        want = answers_due.pop_front();
        check_field("ok", out_tdata[0], want.ok);
        check_field("found", out_tdata[1], want.found);
        check_field("has_plc", out_tdata[2], want.has_plc);
        check_field("has_rtc", out_tdata[3], want.has_rtc);
        check_field("pending", out_tdata[4], want.pending);
        check_field("page_pending_mask", out_tdata[9:5], want.mask);
        check_field("updated_at", out_tdata[41:10], want.updated_at);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_tready <= 1'b0;
    end else begin
      run_left = $urandom_range(1, 30) - 1;
      out_tready <= 1'b1;
    end
  end

  task automatic send_request(request_s r, bit no_gap = 0);
    int gap;
    gap = 0;
    if (!quiet && !no_gap && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.kind;
    in_tdata <= {2'd0, r.new_started_ms, r.new_pending, r.new_has_rtc, r.new_has_plc,
                 r.page_offset, r.category, r.time_ms, r.node_id};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    answers_due.push_back(track_request(r));
  endtask

  function automatic request_s make_request(bit [3:0] kind, bit [31:0] id, bit [31:0] t,
                                            bit [2:0] cat = 0, bit [15:0] off = 0);
    request_s r;
    r = '{default: 0};
    r.kind = kind;
    r.node_id = id;
    r.time_ms = t;
    r.category = cat;
    r.page_offset = off;
    return r;
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, bit [31:0] value);
    in_tvalid <= 1'b0;
    wait (answers_due.size() == 0);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FRESH) fresh_win = value;
    else pend_tmo = value;
    @(posedge clk);
  endtask

  task automatic test_directed();
    request_s r;
    send_request(make_request(K_QUERY, 32'd0, 32'd0));
    send_request(make_request(K_STATUS_UPD, 32'd0, 32'd5));
    send_request(make_request(K_PREP_PAGE, 32'hFFFF_FFFF, 32'hFFFF_FF00, 3'd4, 16'hFFFF));
    send_request(make_request(K_PREP_PAGE, 32'hFFFF_FFFF, 32'h0000_0100, 3'd4, 16'hFFFF));
    send_request(make_request(K_PREP_PAGE, 32'hFFFF_FFFF, 32'h0000_0100, 3'd7, 16'h1));
    send_request(make_request(K_COMPL_PAGE, 32'hFFFF_FFFF, 32'd0, 3'd5, 16'hFFFF));
    send_request(make_request(K_CLEAR_PAGE, 32'hFFFF_FFFF, 32'd0, 3'd6, 16'h0));
    send_request(make_request(K_QUERY, 32'hFFFF_FFFF, 32'd0));
    send_request(make_request(K_COMPL_PAGE, 32'hFFFF_FFFF, 32'd0, 3'd4, 16'hFFFF));
    r = make_request(K_STATUS_UPD, 32'h5, 32'hFFFF_FFF0);
    r.new_has_plc = 1;
    r.new_has_rtc = 1;
    r.new_pending = 1;
    r.new_started_ms = 32'hFFFF_FFFF;
    send_request(r);
    send_request(make_request(K_PREP_STATUS, 32'h5, 32'h0000_0010));
    send_request(make_request(K_CLEAR_PEND, 32'h5, 32'd0));
    send_request(make_request(K_PREP_STATUS, 32'h5, 32'h0000_0010));
    send_request(make_request(K_QUERY, 32'h5, 32'd0));
    send_request(make_request(4'd9, 32'h5, 32'd0));
    send_request(make_request(4'd15, 32'h5, 32'd0));
    for (int i = 1; i <= NSLOT; i++) send_request(make_request(K_PAGE_DATA, 32'd100 + i, i));
    send_request(make_request(K_PREP_STATUS, 32'd999, 32'd1));
    send_request(make_request(K_INVALIDATE, 32'd103, 32'd0));
    send_request(make_request(K_PREP_STATUS, 32'd999, 32'd1));
    for (int i = 1; i <= NSLOT; i++) send_request(make_request(K_INVALIDATE, 32'd100 + i, 0));
    send_request(make_request(K_INVALIDATE, 32'd999, 32'd0));
  endtask

  function automatic request_s random_request();
    request_s r;
    int pick;
    r = '{default: 0};
    pick = $urandom_range(0, 99);
    r.kind = pick < 3 ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    pick = $urandom_range(0, 99);
    r.node_id = pick < 4 ? 32'd0 : pick < 12 ? $urandom : $urandom_range(1, 20);
    clock_ms += $urandom_range(0, 1500);
    r.time_ms = $urandom_range(0, 49) == 0 ? $urandom : clock_ms;
    r.category = $urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
    r.page_offset = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
    r.new_has_plc = 1'($urandom);
    r.new_has_rtc = 1'($urandom);
    r.new_pending = 1'($urandom);
    r.new_started_ms = $urandom_range(0, 9) == 0 ? $urandom : clock_ms - $urandom_range(0, 3000);
    return r;
  endfunction

  task automatic test_register_extremes();
    write_register(REG_FRESH, 32'd0);
    write_register(REG_TIMEOUT, 32'hFFFF_FFFF);
    for (int i = 0; i < 60; i++) send_request(random_request());
    write_register(REG_FRESH, 32'hFFFF_FFFF);
    write_register(REG_TIMEOUT, 32'd0);
    for (int i = 0; i < 60; i++) send_request(random_request());
    write_register(REG_FRESH, FRESH_RST);
    write_register(REG_TIMEOUT, TIMEOUT_RST);
  endtask

  task automatic test_output_stall();
    hold_cycles = 400;
    for (int i = 0; i < 30; i++) send_request(random_request(), 1);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 5; phase++) begin
      write_register(REG_FRESH, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8000));
      write_register(REG_TIMEOUT, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000));
      if (phase == 4) quiet = 1'b1;
      for (int i = 0; i < 330; i++) send_request(random_request());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_output_stall();
    test_random();
    in_tvalid <= 1'b0;
    wait (answers_due.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule

@@ node_request_tracker_table.f @@
rtl/nrt_pkg.sv
rtl/nrt_front.sv
rtl/nrt_back.sv
rtl/node_request_tracker_table.sv
bench/tb.sv
